// File: rtl/core/mode_dependent_periodic_scheduler_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef MODE_DEPENDENT_PERIODIC_SCHEDULER_MACROS_SVH
`define MODE_DEPENDENT_PERIODIC_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS
// Check that a condition implies another in the same cycle.
`define MDPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Check that a condition implies another in the next cycle.
`define MDPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MDPS_ASSERT_NOW(lbl, ante, cons, msg)
`define MDPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/core/mdps_pkg.sv
// Shared types, period table and codes for the periodic scheduler.
package mdps_pkg;

  localparam int unsigned ROM_ROWS = 16;
  localparam int unsigned ROM_COLS = 4;
  localparam int unsigned DW       = 32;

  // Request kinds carried in tuser
  localparam logic OP_TAKE = 1'b0;
  localparam logic OP_INIT = 1'b1;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  // Command from the sequencer to the deadline store
  typedef struct packed {
    logic          init;
    logic          wr;
    logic [3:0]    idx;
    logic [DW-1:0] data;
  } store_cmd_t;

  // Period in ms per job (row) and power state (column); zero disables
  localparam logic [DW-1:0] PERIOD_ROM [ROM_ROWS][ROM_COLS] = '{
    '{32'd60000,   32'd40000,   32'd20000,  32'd0},
    '{32'd300000,  32'd60000,   32'd30000,  32'd0},
    '{32'd3600000, 32'd1800000, 32'd900000, 32'd0},
    '{32'd10000,   32'd5000,    32'd1000,   32'd0},
    '{32'd300000,  32'd120000,  32'd60000,  32'd0},
    '{32'd30000,   32'd15000,   32'd5000,   32'd0},
    '{32'd300000,  32'd60000,   32'd30000,  32'd0},
    '{32'd0,       32'd60000,   32'd30000,  32'd0},
    '{32'd0,       32'd60000,   32'd30000,  32'd0},
    '{32'd30000,   32'd10000,   32'd2000,   32'd0},
    '{32'd0, 32'd0, 32'd0, 32'd0},
    '{32'd0, 32'd0, 32'd0, 32'd0},
    '{32'd0, 32'd0, 32'd0, 32'd0},
    '{32'd0, 32'd0, 32'd0, 32'd0},
    '{32'd0, 32'd0, 32'd0, 32'd0},
    '{32'd0, 32'd0, 32'd0, 32'd0}
  };

endpackage

// File: rtl/core/mode_dependent_periodic_scheduler.sv
// Top level of the mode-dependent periodic scheduler: sequencer and stream ports.
//
// Each request word gives one result word. A take request runs the lookup,
// check and final steps when the job is disabled, not yet due or never run,
// adds the advance and re-check steps when a running job falls due and a
// re-base step when it must also be re-based; an init request goes from the
// lookup to the final step. The steps are set by the single shared 32-bit
// adder, which performs every sum and wrap-safe compare one per cycle under
// the sequencer. s_tready is high only while the sequencer is idle, and a
// result waiting in the output register that is not taken holds the block in
// its final step. Deadlines live in flip-flops and all clear together on init.
`include "mode_dependent_periodic_scheduler_macros.svh"

module mode_dependent_periodic_scheduler #(
  parameter int JOB_COUNT   = 10,
  parameter int STATE_COUNT = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // job[3:0], power_state[5:4], now_tick[37:6], zero
  input  logic [0:0]  s_tuser,   // op[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // due[0], zero
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_CHECK,
    S_ADV,
    S_CHK2,
    S_REBASE,
    S_FINISH
  } state_t;

  state_t                     st;
  logic                       op_r;
  logic [3:0]                 job_r;
  logic [1:0]                 ps_r;
  logic [mdps_pkg::DW-1:0]    now_r;
  logic [mdps_pkg::DW-1:0]    per_r;
  logic [mdps_pkg::DW-1:0]    dl_r;
  logic                       due_r;
  logic                       out_due;

  mdps_pkg::alu_op_t          alu_op;
  logic [mdps_pkg::DW-1:0]    alu_a;
  logic [mdps_pkg::DW-1:0]    alu_b;
  logic [mdps_pkg::DW-1:0]    alu_res;
  logic                       alu_neg;
  mdps_pkg::store_cmd_t       cmd;
  logic [mdps_pkg::DW-1:0]    rd_data;
  logic                       rdy;
  logic                       in_range;
  logic [mdps_pkg::DW-1:0]    period;

  mdps_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .neg (alu_neg)
  );

  mdps_store #(
    .JOB_COUNT (JOB_COUNT)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_idx  (job_r),
    .rd_data (rd_data),
    .rdy     (rdy)
  );

  assign s_tready = (st == S_IDLE);
  assign m_tdata  = {7'd0, out_due};

  // Look up the period; jobs or states beyond the configured counts are off
  assign in_range = ({1'b0, job_r} < 5'(JOB_COUNT)) && ({1'b0, ps_r} < 3'(STATE_COUNT));
  assign period   = in_range ? mdps_pkg::PERIOD_ROM[job_r][ps_r] : '0;

  // Steer the shared adder and the store per step
  always_comb begin
    alu_op   = mdps_pkg::ALU_ADD;
    alu_a    = now_r;
    alu_b    = per_r;
    cmd.init = 1'b0;
    cmd.wr   = 1'b0;
    cmd.idx  = job_r;
    cmd.data = alu_res;
    unique case (st)
      S_LOOKUP: begin
        cmd.init = (op_r == mdps_pkg::OP_INIT);
      end
      S_CHECK: begin
        if (per_r != '0 && rdy) begin
          if (dl_r == '0) begin
            cmd.wr = 1'b1;
          end else begin
            alu_op = mdps_pkg::ALU_SUB;
            alu_b  = dl_r;
          end
        end
      end
      S_ADV: begin
        alu_a = dl_r;
      end
      S_CHK2: begin
        alu_op   = mdps_pkg::ALU_SUB;
        alu_b    = dl_r;
        cmd.wr   = alu_neg;
        cmd.data = dl_r;
      end
      S_REBASE: begin
        cmd.wr = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // Raise the result word from the final step, drop it once taken
      if (st == S_FINISH && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (s_tvalid) begin
            op_r  <= s_tuser[0];
            job_r <= s_tdata[3:0];
            ps_r  <= s_tdata[5:4];
            now_r <= s_tdata[37:6];
            st    <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          per_r <= period;
          dl_r  <= rd_data;
          due_r <= 1'b0;
          st    <= (op_r == mdps_pkg::OP_INIT) ? S_FINISH : S_CHECK;
        end
        S_CHECK: begin
          if (per_r == '0 || !rdy) begin
            st <= S_FINISH;
          end else if (dl_r == '0) begin
            due_r <= 1'b1;
            st    <= S_FINISH;
          end else if (alu_neg) begin
            st <= S_FINISH;
          end else begin
            st <= S_ADV;
          end
        end
        S_ADV: begin
          dl_r <= alu_res;
          st   <= S_CHK2;
        end
        S_CHK2: begin
          due_r <= 1'b1;
          st    <= alu_neg ? S_FINISH : S_REBASE;
        end
        S_REBASE: begin
          st <= S_FINISH;
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            out_due  <= due_r;
            st       <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // A taken request keeps the input closed on the next cycle
  `MDPS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
  // A due result is only possible once the schedule is initialised
  `MDPS_ASSERT_NOW(a_due_needs_ready, m_tvalid && m_tdata[0], rdy, "due before init")
  // An init request sets the ready flag once it has been looked up
  `MDPS_ASSERT_NEXT(a_init_sets_ready, st == S_LOOKUP && op_r == mdps_pkg::OP_INIT, rdy, "init lost")
  // The store is never written outside a take request
  `MDPS_ASSERT_NOW(a_wr_only_take, cmd.wr, op_r == mdps_pkg::OP_TAKE, "write on init")

endmodule

// File: rtl/core/mdps_alu.sv
// Shared 32-bit add/subtract unit with a sign flag for wrap-safe compares.
module mdps_alu (
  input  mdps_pkg::alu_op_t          op,
  input  logic [mdps_pkg::DW-1:0]    a,
  input  logic [mdps_pkg::DW-1:0]    b,
  output logic [mdps_pkg::DW-1:0]    res,
  output logic                       neg
);

  // Add or subtract modulo 2^32
  always_comb begin
    unique case (op)
      mdps_pkg::ALU_ADD: res = a + b;
      mdps_pkg::ALU_SUB: res = a - b;
      default:           res = a + b;
    endcase
  end

  // Sign of the result read as a signed difference
  assign neg = res[mdps_pkg::DW-1];

endmodule

// File: rtl/core/mdps_store.sv
// Per-job deadline registers and the ready flag.
module mdps_store #(
  parameter int JOB_COUNT = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mdps_pkg::store_cmd_t       cmd,
  input  logic [3:0]                 rd_idx,
  output logic [mdps_pkg::DW-1:0]    rd_data,
  output logic                       rdy
);

  localparam int IDX_W = (JOB_COUNT > 1) ? $clog2(JOB_COUNT) : 1;

  logic [mdps_pkg::DW-1:0] dl [JOB_COUNT];
  logic                    rd_ok;
  logic                    wr_ok;

  assign rd_ok = ({1'b0, rd_idx} < 5'(JOB_COUNT));
  assign wr_ok = ({1'b0, cmd.idx} < 5'(JOB_COUNT));

  // Read the selected deadline; out-of-range jobs read as zero
  assign rd_data = rd_ok ? dl[rd_idx[IDX_W-1:0]] : '0;

  // Clear on init, otherwise write one deadline
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < JOB_COUNT; i++) dl[i] <= '0;
      rdy <= 1'b0;
    end else if (cmd.init) begin
      for (int i = 0; i < JOB_COUNT; i++) dl[i] <= '0;
      rdy <= 1'b1;
    end else if (cmd.wr && wr_ok) begin
      dl[cmd.idx[IDX_W-1:0]] <= cmd.data;
    end
  end

endmodule

// File: verif/mode_dependent_periodic_scheduler_tb.sv
// Self-checking bench for the periodic scheduler: directed cases, then random traffic.
module mode_dependent_periodic_scheduler_tb;

  localparam int JOBS   = 10;
  localparam int STATES = 3;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;   // job[3:0], power_state[5:4], now_tick[37:6], zero
  logic [0:0]  s_tuser  = '0;   // op[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // due[0], zero

  // One outstanding answer with the request that caused it
  typedef struct {
    logic        due;
    logic        op;
    logic [3:0]  job;
    logic [1:0]  ps;
    logic [31:0] tick;
  } due_entry_t;

  due_entry_t  pending_due[$];
  logic [31:0] sched_deadline [16];
  logic        sched_ready;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count    = 0;
  int n_items       = 0;
  int n_due         = 0;
  int n_init        = 0;
  logic [31:0] cur_tick;

  mode_dependent_periodic_scheduler #(
    .JOB_COUNT  (JOBS),
    .STATE_COUNT(STATES)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #5000000;
    $display("mode_dependent_periodic_scheduler_tb: FAIL");
    $finish;
  end

  // Period per job and power state; zero means disabled
  function automatic logic [31:0] period_for(logic [3:0] job, logic [1:0] ps);
    logic [95:0] row;
    if (job >= JOBS || ps >= STATES) return 32'd0;
    case (job)
      4'd0: row = {32'd20000, 32'd40000, 32'd60000};
      4'd1: row = {32'd30000, 32'd60000, 32'd300000};
      4'd2: row = {32'd900000, 32'd1800000, 32'd3600000};
      4'd3: row = {32'd1000, 32'd5000, 32'd10000};
      4'd4: row = {32'd60000, 32'd120000, 32'd300000};
      4'd5: row = {32'd5000, 32'd15000, 32'd30000};
      4'd6: row = {32'd30000, 32'd60000, 32'd300000};
      4'd7: row = {32'd30000, 32'd60000, 32'd0};
      4'd8: row = {32'd30000, 32'd60000, 32'd0};
      4'd9: row = {32'd2000, 32'd10000, 32'd30000};
      default: row = '0;
    endcase
    if (ps == 2'd3) return 32'd0;
    return row[ps*32 +: 32];
  endfunction

  // Work out the answer to one request and move the deadline table on
  function automatic logic predict_due(logic op, logic [3:0] job, logic [1:0] ps,
                                       logic [31:0] tick);
    logic [31:0] period;
    logic [31:0] dl;
    logic [31:0] diff;
    integer i;
    if (op == mdps_pkg::OP_INIT) begin
      for (i = 0; i < 16; i++) sched_deadline[i] = 32'd0;
      sched_ready = 1'b1;
      return 1'b0;
    end
    period = period_for(job, ps);
    if (period == 32'd0 || !sched_ready) return 1'b0;
    dl = sched_deadline[job];
    // A cleared deadline means never run: fire at once
    if (dl == 32'd0) begin
      sched_deadline[job] = tick + period;
      return 1'b1;
    end
    diff = tick - dl;
    if (diff[31]) return 1'b0;
    dl   = dl + period;
    diff = tick - dl;
    // Still behind after one period: re-base on the current tick
    if (!diff[31]) dl = tick + period;
    sched_deadline[job] = dl;
    return 1'b1;
  endfunction

  // Receiver: drop tready at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    due_entry_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_due.size() == 0) begin
        $error("unexpected result word: due %0d", m_tdata[0]);
        fail_count++;
      end else begin
        want = pending_due.pop_front();
        if (m_tdata[0] !== want.due) begin
          $error("due mismatch: expected %0d, actual %0d (op %0d job %0d state %0d tick %h)",
                 want.due, m_tdata[0], want.op, want.job, want.ps, want.tick);
          fail_count++;
        end
      end
    end
  end

  // Send one request word and record its expected answer once accepted
  task automatic send_req(input logic op, input logic [3:0] job, input logic [1:0] ps,
                          input logic [31:0] tick);
    due_entry_t ent;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, tick, ps, job};
    do @(posedge clk); while (!s_tready);
    ent.op   = op;
    ent.job  = job;
    ent.ps   = ps;
    ent.tick = tick;
    ent.due  = predict_due(op, job, ps, tick);
    pending_due.push_back(ent);
    n_items++;
    if (ent.due) n_due++;
    if (op == mdps_pkg::OP_INIT) n_init++;
  endtask

  // Hold the sender until every answer is back
  task automatic wait_answers_in;
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_due.size() != 0);
  endtask

  task automatic test_before_init;
    send_req(mdps_pkg::OP_TAKE, 4'd0, 2'd0, 32'd0);
    send_req(mdps_pkg::OP_TAKE, 4'd3, 2'd2, 32'hFFFF_FFFF);
    // Init ignores the other fields, so set them all high
    send_req(mdps_pkg::OP_INIT, 4'hF, 2'd3, 32'hFFFF_FFFF);
  endtask

  task automatic test_reject_cases;
    send_req(mdps_pkg::OP_TAKE, 4'd10, 2'd0, 32'd1234);
    send_req(mdps_pkg::OP_TAKE, 4'd15, 2'd2, 32'd1234);
    send_req(mdps_pkg::OP_TAKE, 4'd0, 2'd3, 32'd1234);
    send_req(mdps_pkg::OP_TAKE, 4'd7, 2'd0, 32'd1234);
    send_req(mdps_pkg::OP_TAKE, 4'd8, 2'd0, 32'hFFFF_FFFF);
  endtask

  task automatic test_first_fire_and_advance;
    send_req(mdps_pkg::OP_TAKE, 4'd0, 2'd0, 32'd0);
    send_req(mdps_pkg::OP_TAKE, 4'd0, 2'd0, 32'd59999);
    send_req(mdps_pkg::OP_TAKE, 4'd0, 2'd0, 32'd60000);
    send_req(mdps_pkg::OP_TAKE, 4'd0, 2'd0, 32'd60000);
  endtask

  task automatic test_deadline_wrap;
    // Lands the deadline exactly on zero, so the next take fires at once
    send_req(mdps_pkg::OP_TAKE, 4'd3, 2'd2, 32'hFFFF_FC18);
    send_req(mdps_pkg::OP_TAKE, 4'd3, 2'd2, 32'd5);
    send_req(mdps_pkg::OP_TAKE, 4'd3, 2'd2, 32'd100);
  endtask

  task automatic test_rebase;
    send_req(mdps_pkg::OP_TAKE, 4'd3, 2'd2, 32'd1005);
    send_req(mdps_pkg::OP_TAKE, 4'd3, 2'd2, 32'd10000);
    send_req(mdps_pkg::OP_TAKE, 4'd3, 2'd2, 32'd10999);
    send_req(mdps_pkg::OP_TAKE, 4'd3, 2'd2, 32'd11000);
  endtask

  task automatic test_half_range;
    send_req(mdps_pkg::OP_TAKE, 4'd1, 2'd1, 32'd100);
    // Distance of exactly half the range reads as negative
    send_req(mdps_pkg::OP_TAKE, 4'd1, 2'd1, 32'd60100 + 32'h8000_0000);
    send_req(mdps_pkg::OP_TAKE, 4'd1, 2'd1, 32'd60100 + 32'h7FFF_FFFF);
  endtask

  task automatic test_reinit;
    send_req(mdps_pkg::OP_INIT, 4'd0, 2'd0, 32'd0);
    send_req(mdps_pkg::OP_TAKE, 4'd0, 2'd0, 32'h1234_5678);
    send_req(mdps_pkg::OP_TAKE, 4'd9, 2'd2, 32'h8000_0000);
  endtask

  // Mostly takes at an advancing tick or near a job's deadline, with some noise
  task automatic test_random_traffic(input int s_idle, input int r_idle, input int n_req);
    int sent;
    int pick;
    logic        op;
    logic [3:0]  job;
    logic [1:0]  ps;
    logic [31:0] tick;
    sent = 0;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    while (sent < n_req) begin
      pick = $urandom_range(99);
      op   = mdps_pkg::OP_TAKE;
      job  = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
      ps   = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
      if (pick < 3) begin
        op   = mdps_pkg::OP_INIT;
        job  = 4'($urandom_range(15));
        ps   = 2'($urandom_range(3));
        tick = $urandom();
      end else if (pick < 8) begin
        job  = 4'($urandom_range(15));
        ps   = 2'($urandom_range(3));
        tick = $urandom();
      end else if (pick < 55) begin
        cur_tick = cur_tick + $urandom_range(3000);
        tick = cur_tick;
      end else if (pick < 83) begin
        tick = sched_deadline[job] + $urandom_range(4) - 32'd2;
      end else if (pick < 93) begin
        cur_tick = cur_tick + $urandom_range(4000000);
        tick = cur_tick;
      end else if (pick < 97) begin
        // Pick the tick that wraps the new deadline onto zero
        tick = 32'd0 - period_for(job, ps);
      end else begin
        cur_tick = 32'hFFFF_0000 + $urandom_range(65535);
        tick = cur_tick;
      end
      sent++;
      send_req(op, job, ps, tick);
      if ($urandom_range(99) == 0) wait_answers_in();
    end
    wait_answers_in();
  endtask

  initial begin
    int spin;
    integer i;
    for (i = 0; i < 16; i++) sched_deadline[i] = 32'd0;
    sched_ready = 1'b0;
    cur_tick    = $urandom();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 30;
    recv_idle_pct = 30;
    test_before_init();
    test_reject_cases();
    test_first_fire_and_advance();
    test_deadline_wrap();
    test_rebase();
    test_half_range();
    test_reinit();
    wait_answers_in();

    test_random_traffic(17, 75, 450);
    test_random_traffic(75, 17, 450);
    test_random_traffic(0, 0, 500);

    // Drain, then give stray words time to show up
    s_tvalid <= 1'b0;
    spin = 0;
    while (pending_due.size() != 0 && spin < 20000) begin
      @(posedge clk);
      spin++;
    end
    repeat (20) @(posedge clk);
    if (pending_due.size() != 0) begin
      $error("%0d expected result words never arrived", pending_due.size());
      fail_count++;
    end

    $display("Covered %0d requests (%0d init, %0d answered due) under three idling mixes,",
             n_items, n_init, n_due);
    $display("with reject cases, deadline wrap, re-base and half-range ticks.");
    if (fail_count == 0) begin
      $display("mode_dependent_periodic_scheduler_tb: PASS");
    end else begin
      $display("mode_dependent_periodic_scheduler_tb: FAIL");
    end
    $finish;
  end

endmodule
